### src/bit_run_length_encoder_top_assert.svh
// Assertion macros used by the bit run-length encoder checker.
`ifndef BIT_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define BIT_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define BRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/brle_pkg.sv
// Package: types and constants of the bit run-length encoder.
`default_nettype none
package brle_pkg;

  // Run counter width and its saturation limit (never above 8 bits).
  localparam int CountWidth = 8;
  localparam logic [7:0] CountLimit =
    (CountWidth >= 8) ? 8'd255 : 8'((64'd1 << CountWidth) - 64'd1);

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // One classified input byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
    logic       first_of_text;
  } brle_item_t;

  // Sequencer states of the back part.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HEAD  = 4'b0010,
    S_BITS  = 4'b0100,
    S_FINAL = 4'b1000
  } brle_state_t;

endpackage
`default_nettype wire

### src/bit_run_length_encoder_top.sv
// Top level of the bit run-length encoder.
//
// Input channel: data_byte and end_of_text move on in_valid/in_ready. Bits
// are read from bit 7 down to 0. The first byte of a text yields a header
// transfer carrying that first bit; every bit change yields the closed run's
// length; a byte marked end_of_text also yields the final run and ends the
// text, so the next byte opens a new one.
// Output channel: run_value, is_header, count_overflow and last_of_item move
// on out_valid/out_ready. last_of_item marks the final transfer of a byte.
// Runs saturate at the counter limit and then carry count_overflow.
// Throughput: the back sequencer walks one bit per cycle unless an emitting
// step meets a stalled output, plus a header step and a final-run step. Results
// leave one per cycle through the output register while the receiver is ready.
// A two-entry queue lets the input keep accepting while a byte is being walked.
// Reset clears the queue, the sequencer and the output register. When the
// receiver stalls the output holds and the sequencer stops at the next
// emitting step; the queue then fills and in_ready drops.
`default_nettype none
module bit_run_length_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_text,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      run_value,
  output logic            is_header,
  output logic            count_overflow,
  output logic            last_of_item,
  output logic            out_valid,
  input  wire logic       out_ready
);

  brle_pkg::brle_item_t q_item;
  logic                 q_valid;
  logic                 q_ready;

  brle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_ready     (q_ready)
  );

  brle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .run_value      (run_value),
    .is_header      (is_header),
    .count_overflow (count_overflow),
    .last_of_item   (last_of_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule
`default_nettype wire

### src/brle_front.sv
// Front part: accepts bytes, marks the first byte of each text, queues them.
`default_nettype none
module brle_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 end_of_text,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output brle_pkg::brle_item_t      q_item,
  output logic                      q_valid,
  input  wire logic                 q_ready
);

  brle_pkg::brle_item_t                 q_mem [brle_pkg::QueueDepth];
  logic [brle_pkg::QueuePtrW-1:0]       wr_ptr;
  logic [brle_pkg::QueuePtrW-1:0]       rd_ptr;
  logic [brle_pkg::QueueCntW-1:0]       q_count;
  logic                                 first_pending;
  logic                                 push;
  logic                                 pop;

  assign in_ready = (q_count != brle_pkg::QueueCntW'(brle_pkg::QueueDepth));
  assign q_valid  = (q_count != '0);
  assign q_item   = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Advance pointers and fill count; track the start of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      q_count       <= '0;
      first_pending <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr        <= (wr_ptr == brle_pkg::QueuePtrW'(brle_pkg::QueueDepth - 1))
                         ? '0 : wr_ptr + 1'b1;
        first_pending <= end_of_text;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == brle_pkg::QueuePtrW'(brle_pkg::QueueDepth - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  // Store the classified byte.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{data_byte: data_byte, end_of_text: end_of_text,
                         first_of_text: first_pending};
    end
  end

endmodule
`default_nettype wire

### src/brle_back.sv
// Back part: walks each byte one bit per cycle unless stalled; emits run items.
`default_nettype none
module brle_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  brle_pkg::brle_item_t      q_item,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  output logic [7:0]                run_value,
  output logic                      is_header,
  output logic                      count_overflow,
  output logic                      last_of_item,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  brle_pkg::brle_state_t state;
  brle_pkg::brle_state_t state_next;
  logic [7:0]            cur_byte;
  logic                  cur_eot;
  logic [2:0]            bit_idx;
  logic                  run_bit;
  logic [7:0]            run_count;
  logic                  run_sat;

  logic                  out_free;
  logic                  cur_bit;
  logic                  is_change;
  logic                  emit;
  logic                  advance;
  logic                  done;
  logic                  item_done;
  logic                  load;
  logic [7:0]            emit_value;
  logic                  emit_header;
  logic                  emit_ovf;
  logic                  emit_last;

  // True when every bit below position idx equals b.
  function automatic logic below_same(input logic [7:0] byte_in,
                                      input logic [2:0] idx, input logic b);
    logic same;
    same = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k < int'(idx) && byte_in[k] != b) begin
        same = 1'b0;
      end
    end
    return same;
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign cur_bit   = cur_byte[bit_idx];
  assign is_change = (cur_bit != run_bit);

  // Decide what the current step emits and whether it completes.
  always_comb begin
    emit        = 1'b0;
    advance     = 1'b1;
    done        = 1'b0;
    emit_value  = run_count;
    emit_header = 1'b0;
    emit_ovf    = run_sat;
    emit_last   = 1'b1;
    unique case (state)
      brle_pkg::S_IDLE: begin
        done = 1'b1;
      end
      brle_pkg::S_HEAD: begin
        emit        = 1'b1;
        advance     = out_free;
        emit_value  = {7'd0, cur_byte[7]};
        emit_header = 1'b1;
        emit_ovf    = 1'b0;
        emit_last   = (cur_byte == 8'h00 || cur_byte == 8'hFF) && !cur_eot;
      end
      brle_pkg::S_BITS: begin
        emit      = is_change;
        advance   = !is_change || out_free;
        done      = (bit_idx == 3'd0) && !cur_eot;
        emit_last = below_same(cur_byte, bit_idx, cur_bit) && !cur_eot;
      end
      brle_pkg::S_FINAL: begin
        emit    = 1'b1;
        advance = out_free;
        done    = 1'b1;
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  assign item_done = advance && done;
  assign q_ready   = item_done;
  assign load      = item_done && q_valid;

  // Pick the next sequencer state.
  always_comb begin
    state_next = state;
    priority if (load) begin
      state_next = q_item.first_of_text ? brle_pkg::S_HEAD : brle_pkg::S_BITS;
    end else if (item_done) begin
      state_next = brle_pkg::S_IDLE;
    end else if (advance) begin
      unique case (state)
        brle_pkg::S_HEAD:  state_next = brle_pkg::S_BITS;
        brle_pkg::S_BITS:  state_next = (bit_idx == 3'd0) ? brle_pkg::S_FINAL
                                                          : brle_pkg::S_BITS;
        default:           state_next = state;
      endcase
    end else begin
      state_next = state;
    end
  end

  // Sequencer, run tracking and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brle_pkg::S_IDLE;
      run_bit   <= 1'b0;
      run_count <= '0;
      run_sat   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        unique case (state)
          brle_pkg::S_HEAD: begin
            run_bit   <= cur_byte[7];
            run_count <= '0;
            run_sat   <= 1'b0;
          end
          brle_pkg::S_BITS: begin
            priority if (is_change) begin
              run_bit   <= cur_bit;
              run_count <= 8'd1;
              run_sat   <= 1'b0;
            end else if (run_count < brle_pkg::CountLimit) begin
              run_count <= run_count + 8'd1;
            end else begin
              run_sat <= 1'b1;
            end
          end
          brle_pkg::S_FINAL: begin
            run_bit   <= 1'b0;
            run_count <= '0;
            run_sat   <= 1'b0;
          end
          default: begin
            run_bit <= run_bit;
          end
        endcase
      end
      if (emit && advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the current byte and bit position; latch each emitted item.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_byte <= q_item.data_byte;
      cur_eot  <= q_item.end_of_text;
      bit_idx  <= 3'd7;
    end else if (advance && state == brle_pkg::S_BITS) begin
      bit_idx <= bit_idx - 3'd1;
    end
    if (emit && advance) begin
      run_value      <= emit_value;
      is_header      <= emit_header;
      count_overflow <= emit_ovf;
      last_of_item   <= emit_last;
    end
  end

endmodule
`default_nettype wire

### src/brle_checker.sv
// Port-level checker for the bit run-length encoder, bound to the top level.
`default_nettype none
`include "bit_run_length_encoder_top_assert.svh"
module brle_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] run_value,
  input wire logic       is_header,
  input wire logic       count_overflow,
  input wire logic       out_valid,
  input wire logic       out_ready
);

  // A header carries a single bit and never an overflow.
  `BRLE_ASSERT_NOW(a_header_bit, out_valid && is_header, run_value[7:1] == 7'd0, "header not a bit")
  `BRLE_ASSERT_NOW(a_header_no_ovf, out_valid && is_header, !count_overflow, "header with overflow")

  // A saturated run reports exactly the counter limit.
  `BRLE_ASSERT_NOW(a_ovf_at_limit, out_valid && count_overflow, run_value == brle_pkg::CountLimit, "overflow below limit")

  // A stalled result holds.
  `BRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(run_value), "stalled result changed")

endmodule

bind bit_run_length_encoder_top brle_checker u_brle_checker (
  .clk            (clk),
  .rst            (rst),
  .run_value      (run_value),
  .is_header      (is_header),
  .count_overflow (count_overflow),
  .out_valid      (out_valid),
  .out_ready      (out_ready)
);
`default_nettype wire

### verif/bit_run_length_encoder_top_test.sv
// Testbench for the bit run-length encoder: random traffic checked against a run predictor.
`default_nettype none
module bit_run_length_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output transfer
  typedef struct packed {
    logic [7:0] value;
    logic       header;
    logic       overflow;
    logic       last;
  } run_item_t;

  // Tracks the run state of the open text and the runs still owed by the block
  class run_tracker;
    logic        text_open;
    logic        cur_bit;
    logic [7:0]  cur_len;
    logic        cur_sat;
    run_item_t   runs_due[$];
    int          errors;
    int          matched;

    function new();
      errors  = 0;
      matched = 0;
      close_text();
    endfunction

    function void close_text();
      text_open = 1'b0;
      cur_bit   = 1'b0;
      cur_len   = 8'd0;
      cur_sat   = 1'b0;
    endfunction

    function void owe_run(logic [7:0] value, logic header, logic overflow);
      run_item_t r;
      r.value    = value;
      r.header   = header;
      r.overflow = overflow;
      r.last     = 1'b0;
      runs_due   = {runs_due, r};
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // Walk one accepted byte, MSB first, and queue the runs it closes
    function void encode_byte(logic [7:0] b, logic eot);
      int        owed_before;
      run_item_t r;
      owed_before = runs_due.size();
      if (!text_open) begin
        owe_run({7'd0, b[7]}, 1'b1, 1'b0);
        text_open = 1'b1;
        cur_bit   = b[7];
        cur_len   = 8'd0;
        cur_sat   = 1'b0;
      end
      for (int j = 7; j >= 0; j--) begin
        if (b[j] != cur_bit) begin
          owe_run(cur_len, 1'b0, cur_sat);
          cur_len = 8'd1;
          cur_sat = 1'b0;
          cur_bit = b[j];
        end else if (cur_len < brle_pkg::CountLimit) begin
          cur_len = cur_len + 8'd1;
        end else begin
          cur_sat = 1'b1;
        end
      end
      if (eot) begin
        owe_run(cur_len, 1'b0, cur_sat);
        close_text();
      end
      // Mark the final transfer caused by this byte
      if (runs_due.size() > owed_before) begin
        r = runs_due[runs_due.size() - 1];
        r.last = 1'b1;
        runs_due[runs_due.size() - 1] = r;
      end
    endfunction

    function void report(string what, int want, int got);
      errors++;
      if (errors <= 60)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Compare one output transfer with the oldest owed run
    function void match_run(logic [7:0] value, logic header, logic overflow, logic last);
      run_item_t r;
      if (runs_due.size() == 0) begin
        errors++;
        if (errors <= 60)
          $display("%0t: unexpected transfer: expected none, actual value=%0d hdr=%0d ovf=%0d last=%0d",
                   $time, value, header, overflow, last);
        return;
      end
      r = runs_due.pop_front();
      matched++;
      if (value !== r.value) report("run_value", r.value, value);
      if (header !== r.header) report("is_header", r.header, header);
      if (overflow !== r.overflow) report("count_overflow", r.overflow, overflow);
      if (last !== r.last) report("last_of_item", r.last, last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic [7:0] data_byte;
  logic       end_of_text;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] run_value;
  logic       is_header;
  logic       count_overflow;
  logic       last_of_item;
  logic       out_valid;
  logic       out_ready;

  run_tracker runs = new();
  int         bytes_sent = 0;
  logic       calm_sender = 1'b0;
  logic       hold_done = 1'b0;

  bit_run_length_encoder_top uut (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_text    (end_of_text),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .run_value      (run_value),
    .is_header      (is_header),
    .count_overflow (count_overflow),
    .last_of_item   (last_of_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Record both channels' transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) runs.encode_byte(data_byte, end_of_text);
      if (out_valid && out_ready)
        runs.match_run(run_value, is_header, count_overflow, last_of_item);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and hold it until the transfer; returns at that rising edge
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = calm_sender ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_byte   <= b;
    end_of_text <= eot;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send a text of random bytes, some of them solid, eot on the last
  task automatic send_text(input int len, input int solid_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < solid_pct) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Long solid run, ending on a random byte: with enough bytes it reaches and passes the counter limit
  task automatic send_long_run(input int len);
    logic [7:0] fill;
    fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    for (int i = 0; i < len; i++) send_byte(fill, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: random stalls, ready bursts, and one long hold-off to back up the input
  initial begin
    int stall_left;
    int burst_left;
    int r;
    stall_left = 0;
    burst_left = 0;
    out_ready  = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!hold_done && runs.matched >= 120) begin
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 15) burst_left = $urandom_range(20, 60);
        else if (r < 50) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int text_no;
    int kind;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = 8'd0;
    end_of_text = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-byte texts: solid, alternating, edge bits
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFE, 1'b1);
    // Multi-byte text with runs across byte borders
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b1);
    // Run spanning bytes; the middle byte causes no transfer
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random texts; the first one saturates the counter
    text_no = 0;
    while (bytes_sent < 305) begin
      calm_sender = ($urandom_range(0, 3) == 0);
      kind = (text_no == 0) ? 0 : $urandom_range(0, 9);
      if (kind < 2) send_long_run((text_no == 0) ? 33 : $urandom_range(30, 35));
      else if (kind == 2) send_text(1, 0);
      else send_text($urandom_range(1, 8), $urandom_range(0, 1) ? 40 : 0);
      text_no++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then let the block settle
    while (runs.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (runs.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
